FILE: hw/rtl/ecp_pkg.sv
package ecp_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = WORD_BITS - 1;
   localparam int DIV_BITS  = 2 * WORD_BITS;
   localparam int REM_BITS  = WORD_BITS + 1;
   localparam int LANES     = 4;
   localparam int KE_LANE   = 3;
   localparam int LO_BITS   = 32;
   localparam int HI_BITS   = WORD_BITS + FRAC_BITS - LO_BITS;
   localparam int PROD_BITS = LO_BITS + HI_BITS + COEF_BITS;

   localparam logic [COEF_BITS-1:0] COEF_RESET = COEF_BITS'(163840);
   localparam logic [DIV_BITS-1:0]  SIGN_MAG   = DIV_BITS'(1) << (WORD_BITS - 1);
   localparam logic [DIV_BITS-1:0]  POS_MAX    = SIGN_MAG - DIV_BITS'(1);

   typedef logic signed [WORD_BITS-1:0] word_type;

   // one division transaction as it travels down the cell row
   typedef struct packed {
      logic                             valid;
      logic                             bad;
      logic [WORD_BITS-1:0]             density;
      logic [WORD_BITS-1:0]             rmag;
      logic [2:0]                       mneg;
      logic                             eneg;
      logic [WORD_BITS-1:0]             emag;
      logic [LANES-1:0][DIV_BITS-1:0]   num;
      logic [LANES-1:0][REM_BITS-1:0]   rem;
      logic [LANES-1:0][DIV_BITS-1:0]   quo;
   } div_type;

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] word;
   } clip_type;

   // two's complement word to magnitude
   function automatic logic [WORD_BITS-1:0] magnitude(input logic [WORD_BITS-1:0] v);
      return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
   endfunction

   // sign and magnitude to a saturated word
   function automatic clip_type clip(input logic [DIV_BITS-1:0] mag, input logic neg);
      clip_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > SIGN_MAG) begin
            r.sat  = 1'b1;
            r.word = SIGN_MAG[WORD_BITS-1:0];
         end else begin
            r.word = ~mag[WORD_BITS-1:0] + WORD_BITS'(1);
         end
      end else begin
         if (mag > POS_MAX) begin
            r.sat  = 1'b1;
            r.word = POS_MAX[WORD_BITS-1:0];
         end else begin
            r.word = mag[WORD_BITS-1:0];
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/ecp_if.sv
interface ecp_req_if;
   logic                         valid;
   logic                         ready;
   logic [ecp_pkg::WORD_BITS-1:0] density;
   logic [ecp_pkg::WORD_BITS-1:0] mom_x;
   logic [ecp_pkg::WORD_BITS-1:0] mom_y;
   logic [ecp_pkg::WORD_BITS-1:0] mom_z;
   logic [ecp_pkg::WORD_BITS-1:0] total_energy;
   modport source (output valid, density, mom_x, mom_y, mom_z, total_energy, input ready);
   modport sink (input valid, density, mom_x, mom_y, mom_z, total_energy, output ready);
endinterface

interface ecp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ecp_pkg::WORD_BITS-1:0] density_out;
   logic [ecp_pkg::WORD_BITS-1:0] vel_x;
   logic [ecp_pkg::WORD_BITS-1:0] vel_y;
   logic [ecp_pkg::WORD_BITS-1:0] vel_z;
   logic [ecp_pkg::WORD_BITS-1:0] pressure;
   logic                         bad_density;
   logic                         saturated;
   modport source (output valid, density_out, vel_x, vel_y, vel_z, pressure, bad_density,
                   saturated, input ready);
   modport sink (input valid, density_out, vel_x, vel_y, vel_z, pressure, bad_density,
                 saturated, output ready);
endinterface

interface ecp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ecp_pkg::COEF_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/euler_cons_to_prim_core.sv
// Conservative to primitive conversion for one ideal-gas cell in signed Q16.16.
// A transaction is accepted every cycle while the result side keeps up; each one
// is offered on rsp once it has passed through every stage. There are 69 register
// stages: two front stages (magnitudes, squares, sum of squares), a row of 64
// division cells that each settle one quotient bit for the three velocities and
// the kinetic energy, then difference, multiply and clip stages.
// The whole row stalls together while a finished result waits, so req.ready
// follows rsp.ready. The coefficient register sits on csr and is always ready;
// write it only while no transaction is in flight.
module euler_cons_to_prim_core (
   input  logic     clock,
   input  logic     reset,
   ecp_req_if.sink  req,
   ecp_rsp_if.source rsp,
   ecp_csr_if.sink  csr
);

   localparam int NUM_CELLS = ecp_pkg::DIV_BITS;

   logic                           en;
   logic [ecp_pkg::COEF_BITS-1:0]  coef_ff;
   ecp_pkg::div_type               row [NUM_CELLS+1];

   // pipeline advance
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   // coefficient register
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= ecp_pkg::COEF_RESET;
      end else if (csr.valid) begin
         coef_ff <= csr.data;
      end
   end

   ecp_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req.valid),
      .density      (req.density),
      .mom_x        (req.mom_x),
      .mom_y        (req.mom_y),
      .mom_z        (req.mom_z),
      .total_energy (req.total_energy),
      .out          (row[0])
   );

   // division cell row
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ecp_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in    (row[i]),
         .out   (row[i+1])
      );
   end

   ecp_post u_post (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .coef        (coef_ff),
      .in          (row[NUM_CELLS]),
      .out_valid   (rsp.valid),
      .density_out (rsp.density_out),
      .vel_x       (rsp.vel_x),
      .vel_y       (rsp.vel_y),
      .vel_z       (rsp.vel_z),
      .pressure    (rsp.pressure),
      .bad_density (rsp.bad_density),
      .saturated   (rsp.saturated)
   );

   // checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_density |->
         rsp.vel_x == '0 && rsp.vel_y == '0 && rsp.vel_z == '0 && rsp.pressure == '0)
      else $error("bad density result not zeroed");

   a_bad_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_density |-> !rsp.saturated)
      else $error("saturated set with bad density");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while result stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

endmodule

FILE: hw/rtl/ecp_prep.sv
module ecp_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [ecp_pkg::WORD_BITS-1:0] density,
   input  logic [ecp_pkg::WORD_BITS-1:0] mom_x,
   input  logic [ecp_pkg::WORD_BITS-1:0] mom_y,
   input  logic [ecp_pkg::WORD_BITS-1:0] mom_z,
   input  logic [ecp_pkg::WORD_BITS-1:0] total_energy,
   output ecp_pkg::div_type              out
);

   logic                                  valid_a_ff;
   logic                                  bad_a_ff;
   logic [ecp_pkg::WORD_BITS-1:0]         density_a_ff;
   logic [ecp_pkg::WORD_BITS-1:0]         rmag_a_ff;
   logic [2:0]                            mneg_a_ff;
   logic                                  eneg_a_ff;
   logic [ecp_pkg::WORD_BITS-1:0]         emag_a_ff;
   logic [2:0][ecp_pkg::WORD_BITS-1:0]    mmag_a_ff;
   logic [2:0][ecp_pkg::DIV_BITS-1:0]     sq_a_ff;
   logic [2:0][ecp_pkg::WORD_BITS-1:0]    mom;
   logic [2:0][ecp_pkg::WORD_BITS-1:0]    mmag;
   ecp_pkg::div_type                      out_in;
   ecp_pkg::div_type                      out_ff;

   assign mom = {mom_z, mom_y, mom_x};

   // magnitudes of the momenta
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mmag[k] = ecp_pkg::magnitude(mom[k]);
      end
   end

   // first stage: magnitudes and squares
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
      if (en) begin
         bad_a_ff     <= density[ecp_pkg::WORD_BITS-1] || (density == '0);
         density_a_ff <= density;
         rmag_a_ff    <= ecp_pkg::magnitude(density);
         eneg_a_ff    <= total_energy[ecp_pkg::WORD_BITS-1];
         emag_a_ff    <= ecp_pkg::magnitude(total_energy);
         for (int k = 0; k < 3; k++) begin
            mneg_a_ff[k] <= mom[k][ecp_pkg::WORD_BITS-1];
            mmag_a_ff[k] <= mmag[k];
            sq_a_ff[k]   <= ecp_pkg::DIV_BITS'(mmag[k]) * ecp_pkg::DIV_BITS'(mmag[k]);
         end
      end
   end

   // second stage: sum of squares and dividends
   always_comb begin
      out_in         = '0;
      out_in.valid   = valid_a_ff;
      out_in.bad     = bad_a_ff;
      out_in.density = density_a_ff;
      out_in.rmag    = rmag_a_ff;
      out_in.mneg    = mneg_a_ff;
      out_in.eneg    = eneg_a_ff;
      out_in.emag    = emag_a_ff;
      for (int k = 0; k < 3; k++) begin
         out_in.num[k] = ecp_pkg::DIV_BITS'(mmag_a_ff[k]) << ecp_pkg::FRAC_BITS;
      end
      out_in.num[ecp_pkg::KE_LANE] = sq_a_ff[0] + sq_a_ff[1] + sq_a_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.bad     <= out_in.bad;
         out_ff.density <= out_in.density;
         out_ff.rmag    <= out_in.rmag;
         out_ff.mneg    <= out_in.mneg;
         out_ff.eneg    <= out_in.eneg;
         out_ff.emag    <= out_in.emag;
         out_ff.num     <= out_in.num;
         out_ff.rem     <= out_in.rem;
         out_ff.quo     <= out_in.quo;
      end
   end

   assign out = out_ff;

endmodule

FILE: hw/rtl/ecp_cell.sv
module ecp_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  ecp_pkg::div_type in,
   output ecp_pkg::div_type out
);

   ecp_pkg::div_type              out_in;
   ecp_pkg::div_type              out_ff;
   logic [ecp_pkg::REM_BITS-1:0]  divisor;
   logic [ecp_pkg::REM_BITS:0]    trial;

   // one restoring quotient bit for every lane
   always_comb begin
      out_in  = in;
      divisor = '0;
      trial   = '0;
      for (int k = 0; k < ecp_pkg::LANES; k++) begin
         if (k == ecp_pkg::KE_LANE) begin
            divisor = {in.rmag, 1'b0};
         end else begin
            divisor = {1'b0, in.rmag};
         end
         trial = {in.rem[k], in.num[k][ecp_pkg::DIV_BITS-1]};
         out_in.num[k] = in.num[k] << 1;
         if (trial >= {1'b0, divisor}) begin
            out_in.rem[k] = ecp_pkg::REM_BITS'(trial - {1'b0, divisor});
            out_in.quo[k] = {in.quo[k][ecp_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            out_in.rem[k] = trial[ecp_pkg::REM_BITS-1:0];
            out_in.quo[k] = {in.quo[k][ecp_pkg::DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff.valid <= out_in.valid;
      end
      if (en) begin
         out_ff.bad     <= out_in.bad;
         out_ff.density <= out_in.density;
         out_ff.rmag    <= out_in.rmag;
         out_ff.mneg    <= out_in.mneg;
         out_ff.eneg    <= out_in.eneg;
         out_ff.emag    <= out_in.emag;
         out_ff.num     <= out_in.num;
         out_ff.rem     <= out_in.rem;
         out_ff.quo     <= out_in.quo;
      end
   end

   assign out = out_ff;

endmodule

FILE: hw/rtl/ecp_post.sv
module ecp_post (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [ecp_pkg::COEF_BITS-1:0]  coef,
   input  ecp_pkg::div_type               in,
   output logic                           out_valid,
   output logic [ecp_pkg::WORD_BITS-1:0]  density_out,
   output logic [ecp_pkg::WORD_BITS-1:0]  vel_x,
   output logic [ecp_pkg::WORD_BITS-1:0]  vel_y,
   output logic [ecp_pkg::WORD_BITS-1:0]  vel_z,
   output logic [ecp_pkg::WORD_BITS-1:0]  pressure,
   output logic                           bad_density,
   output logic                           saturated
);

   logic [2:0]                          valid_ff;
   logic [1:0]                          bad_ff;
   logic [1:0][ecp_pkg::WORD_BITS-1:0]  density_ff;
   logic [1:0][2:0]                     mneg_ff;
   logic [1:0][2:0][ecp_pkg::DIV_BITS-1:0] vq_ff;
   logic [1:0]                          dneg_ff;
   logic [1:0]                          big_ff;
   logic [ecp_pkg::LO_BITS-1:0]         lo_ff;
   logic [ecp_pkg::HI_BITS-1:0]         hi_ff;
   logic                                czero_ff;
   logic [ecp_pkg::LO_BITS+ecp_pkg::COEF_BITS-1:0] plo_ff;
   logic [ecp_pkg::HI_BITS+ecp_pkg::COEF_BITS-1:0] phi_ff;
   logic [ecp_pkg::DIV_BITS-1:0]        ke;
   logic [ecp_pkg::DIV_BITS-1:0]        emag_w;
   logic [ecp_pkg::DIV_BITS-1:0]        dmag;
   logic                                dneg;
   logic [ecp_pkg::PROD_BITS-1:0]       prod;
   logic [ecp_pkg::DIV_BITS-1:0]        pmag;
   ecp_pkg::clip_type                   cx, cy, cz, cp;
   logic [ecp_pkg::WORD_BITS-1:0]       vel_x_ff, vel_y_ff, vel_z_ff, pressure_ff;
   logic [ecp_pkg::WORD_BITS-1:0]       density_out_ff;
   logic                                bad_density_ff, saturated_ff;

   // internal energy as sign and magnitude
   always_comb begin
      ke     = in.quo[ecp_pkg::KE_LANE];
      emag_w = ecp_pkg::DIV_BITS'(in.emag);
      if (in.eneg) begin
         dneg = 1'b1;
         dmag = emag_w + ke;
      end else if (emag_w >= ke) begin
         dneg = 1'b0;
         dmag = emag_w - ke;
      end else begin
         dneg = 1'b1;
         dmag = ke - emag_w;
      end
   end

   // pressure product and final clipping
   always_comb begin
      prod = (ecp_pkg::PROD_BITS'(phi_ff) << ecp_pkg::LO_BITS) + ecp_pkg::PROD_BITS'(plo_ff);
      pmag = ecp_pkg::DIV_BITS'(prod >> ecp_pkg::FRAC_BITS);
      if (big_ff[1] && !czero_ff) begin
         pmag = '1;
      end
      cx = ecp_pkg::clip(vq_ff[1][0], mneg_ff[1][0]);
      cy = ecp_pkg::clip(vq_ff[1][1], mneg_ff[1][1]);
      cz = ecp_pkg::clip(vq_ff[1][2], mneg_ff[1][2]);
      cp = ecp_pkg::clip(pmag, dneg_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in.valid};
      end
      if (en) begin
         // difference stage
         bad_ff[0]     <= in.bad;
         density_ff[0] <= in.density;
         mneg_ff[0]    <= in.mneg;
         vq_ff[0]      <= in.quo[2:0];
         dneg_ff[0]    <= dneg;
         big_ff[0]     <= |dmag[ecp_pkg::DIV_BITS-1:ecp_pkg::LO_BITS+ecp_pkg::HI_BITS];
         lo_ff         <= dmag[ecp_pkg::LO_BITS-1:0];
         hi_ff         <= dmag[ecp_pkg::LO_BITS+ecp_pkg::HI_BITS-1:ecp_pkg::LO_BITS];
         // multiply stage
         bad_ff[1]     <= bad_ff[0];
         density_ff[1] <= density_ff[0];
         mneg_ff[1]    <= mneg_ff[0];
         vq_ff[1]      <= vq_ff[0];
         dneg_ff[1]    <= dneg_ff[0];
         big_ff[1]     <= big_ff[0];
         czero_ff      <= (coef == '0);
         plo_ff        <= (ecp_pkg::LO_BITS+ecp_pkg::COEF_BITS)'(lo_ff) *
                          (ecp_pkg::LO_BITS+ecp_pkg::COEF_BITS)'(coef);
         phi_ff        <= (ecp_pkg::HI_BITS+ecp_pkg::COEF_BITS)'(hi_ff) *
                          (ecp_pkg::HI_BITS+ecp_pkg::COEF_BITS)'(coef);
         // result register
         density_out_ff <= density_ff[1];
         bad_density_ff <= bad_ff[1];
         if (bad_ff[1]) begin
            vel_x_ff     <= '0;
            vel_y_ff     <= '0;
            vel_z_ff     <= '0;
            pressure_ff  <= '0;
            saturated_ff <= 1'b0;
         end else begin
            vel_x_ff     <= cx.word;
            vel_y_ff     <= cy.word;
            vel_z_ff     <= cz.word;
            pressure_ff  <= cp.word;
            saturated_ff <= cx.sat || cy.sat || cz.sat || cp.sat;
         end
      end
   end

   assign out_valid   = valid_ff[2];
   assign density_out = density_out_ff;
   assign vel_x       = vel_x_ff;
   assign vel_y       = vel_y_ff;
   assign vel_z       = vel_z_ff;
   assign pressure    = pressure_ff;
   assign bad_density = bad_density_ff;
   assign saturated   = saturated_ff;

endmodule
